FILE: sv/dcs_pkg.sv
// Shared constants, types and helpers for the dense Cholesky solver.
// No dependencies; imported by dcs_arith and dense_cholesky_solver.
package dcs_pkg;

  localparam int MAX_DIM   = 64;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int WORD_W    = 32;
  localparam int ACC_W     = 64;
  localparam int MAT_DEPTH = MAX_DIM * MAX_DIM;
  localparam int MAT_AW    = 2 * IDX_W;

  localparam logic [CNT_W-1:0] SIZE_RESET = 7'd6;

  // item kinds carried in in_tuser
  localparam logic [1:0] MODE_LOAD_MAT = 2'd0;
  localparam logic [1:0] MODE_LOAD_RHS = 2'd1;
  localparam logic [1:0] MODE_SOLVE    = 2'd2;

  // solve phases
  localparam logic [1:0] PH_FAC = 2'd0;
  localparam logic [1:0] PH_FWD = 2'd1;
  localparam logic [1:0] PH_BWD = 2'd2;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_rsp_t;

  // Q16.16 product rounded to nearest, ties towards plus infinity
  function automatic logic signed [ACC_W-1:0] qround(input logic signed [ACC_W-1:0] p);
    logic signed [ACC_W-1:0] s;
    s = p + 64'sd32768;
    return s >>> 16;
  endfunction

endpackage

FILE: sv/dense_cholesky_solver.sv
// Load items write the matrix and right-hand-side RAMs at one item a cycle. A solve item
// blocks the input until the last result is queued: it factors the matrix and then runs the
// forward and backward substitutions. Its run time is set by the single multiply-accumulate
// loop (read, multiply and accumulate states per product, one RAM read each) and the shared
// iterative unit, which does every division and square root. Results leave through an output
// register; a failed pivot gives a single flagged result.
// Top level; depends on dcs_pkg, dcs_ram and dcs_arith.
module dense_cholesky_solver
  import dcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // row_index[5:0], col_index[11:6], entry_value[43:12]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // solution_index[5:0], solution_value[37:6]
  output logic [0:0]  out_tuser,  // not_positive_definite[0]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DOT_RD  = 4'd1;
  localparam logic [3:0] S_DOT_MUL = 4'd2;
  localparam logic [3:0] S_DOT_ACC = 4'd3;
  localparam logic [3:0] S_TAIL_RD = 4'd4;
  localparam logic [3:0] S_TAIL    = 4'd5;
  localparam logic [3:0] S_WAIT    = 4'd6;
  localparam logic [3:0] S_WB      = 4'd7;
  localparam logic [3:0] S_OUT_RD  = 4'd8;
  localparam logic [3:0] S_OUT_LD  = 4'd9;
  localparam logic [3:0] S_ERR     = 4'd10;

  logic [3:0]              state_r, state_nxt;
  logic [1:0]              phase_r, phase_nxt;
  logic [CNT_W-1:0]        j_r, j_nxt, i_r, i_nxt, k_r, k_nxt, kend_r, kend_nxt;
  logic [CNT_W-1:0]        size_r, n_dim;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, prod_r, prod_nxt;
  logic [WORD_W-1:0]       piv_r, piv_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]        out_idx_r, out_idx_nxt;
  logic [WORD_W-1:0]       out_val_r, out_val_nxt;
  logic                    out_err_r, out_err_nxt, out_last_r, out_last_nxt;

  logic                    in_acc;
  logic [1:0]              in_mode;
  logic [IDX_W-1:0]        in_row, in_col;
  logic [WORD_W-1:0]       in_val;

  logic                    mat_we, rhs_we;
  logic [MAT_AW-1:0]       mat_waddr, mat_a_raddr, mat_b_raddr;
  logic [IDX_W-1:0]        rhs_waddr, rhs_raddr;
  logic [WORD_W-1:0]       mat_wdata, rhs_wdata, mat_a_rdata, mat_b_rdata, rhs_rdata;

  arith_req_t              ar_req;
  arith_rsp_t              ar_rsp;
  logic signed [ACC_W-1:0] ar_num;
  logic [WORD_W-1:0]       ar_den, ar_res;
  logic [30:0]             ar_rad;

  logic                    is_fac, is_bwd, is_diag, slot_free;

  assign in_mode   = in_tuser;
  assign in_row    = in_tdata[5:0];
  assign in_col    = in_tdata[11:6];
  assign in_val    = in_tdata[43:12];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign n_dim     = (size_r == '0) ? 7'd1 :
                     (size_r > 7'(MAX_DIM)) ? 7'(MAX_DIM) : size_r;
  assign is_fac    = (phase_r == PH_FAC);
  assign is_bwd    = (phase_r == PH_BWD);
  assign is_diag   = is_fac && (i_r == j_r);
  assign slot_free = !out_valid_r || out_tready;

  // read addresses
  always_comb begin
    if (state_r == S_TAIL_RD || state_r == S_TAIL) begin
      mat_a_raddr = is_fac ? {i_r[IDX_W-1:0], j_r[IDX_W-1:0]}
                           : {i_r[IDX_W-1:0], i_r[IDX_W-1:0]};
    end else if (is_bwd) begin
      mat_a_raddr = {k_r[IDX_W-1:0], i_r[IDX_W-1:0]};
    end else begin
      mat_a_raddr = {i_r[IDX_W-1:0], k_r[IDX_W-1:0]};
    end
    mat_b_raddr = {j_r[IDX_W-1:0], k_r[IDX_W-1:0]};
    if (state_r == S_TAIL_RD || state_r == S_TAIL || state_r == S_OUT_RD ||
        state_r == S_OUT_LD) begin
      rhs_raddr = i_r[IDX_W-1:0];
    end else begin
      rhs_raddr = k_r[IDX_W-1:0];
    end
  end

  // write ports: loads while idle, write-back during a solve
  always_comb begin
    mat_we    = 1'b0;
    rhs_we    = 1'b0;
    mat_waddr = {in_row, in_col};
    mat_wdata = in_val;
    rhs_waddr = in_row;
    rhs_wdata = in_val;
    if (state_r == S_WB) begin
      mat_we    = is_fac;
      rhs_we    = !is_fac;
      mat_waddr = {i_r[IDX_W-1:0], j_r[IDX_W-1:0]};
      mat_wdata = ar_res;
      rhs_waddr = i_r[IDX_W-1:0];
      rhs_wdata = ar_res;
    end else if (in_acc) begin
      mat_we = (in_mode == MODE_LOAD_MAT) && (in_col <= in_row);
      rhs_we = (in_mode == MODE_LOAD_RHS);
    end
  end

  // two copies of the matrix give two read ports
  dcs_ram #(.WIDTH(WORD_W), .DEPTH(MAT_DEPTH)) u_mat_a (
    .clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(mat_wdata),
    .raddr(mat_a_raddr), .rdata(mat_a_rdata)
  );

  dcs_ram #(.WIDTH(WORD_W), .DEPTH(MAT_DEPTH)) u_mat_b (
    .clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(mat_wdata),
    .raddr(mat_b_raddr), .rdata(mat_b_rdata)
  );

  dcs_ram #(.WIDTH(WORD_W), .DEPTH(MAX_DIM)) u_rhs (
    .clk(clk), .we(rhs_we), .waddr(rhs_waddr), .wdata(rhs_wdata),
    .raddr(rhs_raddr), .rdata(rhs_rdata)
  );

  dcs_arith u_arith (
    .clk(clk), .rst_n(rst_n), .req(ar_req), .num(ar_num), .den(ar_den),
    .rad(ar_rad), .rsp(ar_rsp), .result(ar_res)
  );

  assign ar_num = (is_fac ? ACC_W'($signed(mat_a_rdata)) : ACC_W'($signed(rhs_rdata))) - acc_r;
  assign ar_den = is_fac ? piv_r : mat_a_rdata;
  assign ar_rad = ar_num[30:0];

  always_comb begin
    logic signed [WORD_W-1:0] op_a, op_b;
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    j_nxt         = j_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    kend_nxt      = kend_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    piv_nxt       = piv_r;
    out_idx_nxt   = out_idx_r;
    out_val_nxt   = out_val_r;
    out_err_nxt   = out_err_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ar_req.start  = 1'b0;
    ar_req.is_sqrt = is_diag;
    op_a          = $signed(mat_a_rdata);
    op_b          = is_fac ? $signed(mat_b_rdata) : $signed(rhs_rdata);
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_mode == MODE_SOLVE) begin
          phase_nxt = PH_FAC;
          j_nxt     = '0;
          i_nxt     = '0;
          k_nxt     = '0;
          kend_nxt  = '0;
          acc_nxt   = '0;
          state_nxt = S_DOT_RD;
        end
      end
      S_DOT_RD: begin
        state_nxt = (k_r == kend_r) ? S_TAIL_RD : S_DOT_MUL;
      end
      S_DOT_MUL: begin
        prod_nxt  = ACC_W'(op_a) * ACC_W'(op_b);
        state_nxt = S_DOT_ACC;
      end
      S_DOT_ACC: begin
        acc_nxt   = acc_r + qround(prod_r);
        k_nxt     = k_r + 7'd1;
        state_nxt = S_DOT_RD;
      end
      S_TAIL_RD: begin
        state_nxt = S_TAIL;
      end
      S_TAIL: begin
        if (is_diag && (ar_num[ACC_W-1] || ar_num == '0)) begin
          state_nxt = S_ERR;
        end else begin
          ar_req.start = 1'b1;
          state_nxt    = S_WAIT;
        end
      end
      S_WAIT: begin
        if (ar_rsp.done) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        acc_nxt   = '0;
        state_nxt = S_DOT_RD;
        unique case (phase_r)
          PH_FAC: begin
            if (is_diag) begin
              piv_nxt = ar_res;
            end
            if (i_r + 7'd1 < n_dim) begin
              i_nxt    = i_r + 7'd1;
              k_nxt    = '0;
              kend_nxt = j_r;
            end else if (j_r + 7'd1 < n_dim) begin
              j_nxt    = j_r + 7'd1;
              i_nxt    = j_r + 7'd1;
              k_nxt    = '0;
              kend_nxt = j_r + 7'd1;
            end else begin
              phase_nxt = PH_FWD;
              i_nxt     = '0;
              k_nxt     = '0;
              kend_nxt  = '0;
            end
          end
          PH_FWD: begin
            if (i_r + 7'd1 < n_dim) begin
              i_nxt    = i_r + 7'd1;
              k_nxt    = '0;
              kend_nxt = i_r + 7'd1;
            end else begin
              phase_nxt = PH_BWD;
              i_nxt     = n_dim - 7'd1;
              k_nxt     = n_dim;
              kend_nxt  = n_dim;
            end
          end
          default: begin
            if (i_r == '0) begin
              state_nxt = S_OUT_RD;
            end else begin
              i_nxt    = i_r - 7'd1;
              k_nxt    = i_r;
              kend_nxt = n_dim;
            end
          end
        endcase
      end
      S_OUT_RD: begin
        state_nxt = S_OUT_LD;
      end
      S_OUT_LD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = i_r[IDX_W-1:0];
          out_val_nxt   = rhs_rdata;
          out_err_nxt   = 1'b0;
          out_last_nxt  = (i_r == n_dim - 7'd1);
          if (i_r == n_dim - 7'd1) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + 7'd1;
            state_nxt = S_OUT_RD;
          end
        end
      end
      S_ERR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = '0;
          out_val_nxt   = '0;
          out_err_nxt   = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_FAC;
      size_r      <= SIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        size_r <= cfg_data;
      end
    end
    j_r        <= j_nxt;
    i_r        <= i_nxt;
    k_r        <= k_nxt;
    kend_r     <= kend_nxt;
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    piv_r      <= piv_nxt;
    out_idx_r  <= out_idx_nxt;
    out_val_r  <= out_val_nxt;
    out_err_r  <= out_err_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_val_r, out_idx_r};
  assign out_tuser  = out_err_r;
  assign out_tlast  = out_last_r;

  a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    ar_req.start |-> !ar_rsp.busy)
    else $error("arithmetic unit started while busy");

  a_wb_only: assert property (@(posedge clk) disable iff (!rst_n)
    (mat_we || rhs_we) && state_r != S_IDLE |-> state_r == S_WB)
    else $error("RAM written outside write-back during a solve");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_last_r)
    else $error("error result without last");

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DOT_RD |-> k_r <= kend_r)
    else $error("dot product index ran past its end");

endmodule

FILE: sv/dcs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/dcs_arith.sv
// Iterative arithmetic unit: Q16.16 saturating division (one quotient bit a cycle)
// and integer square root (one result bit a cycle). Depends on dcs_pkg.
module dcs_arith
  import dcs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  arith_req_t              req,
  input  logic signed [ACC_W-1:0] num,
  input  logic [WORD_W-1:0]       den,
  input  logic [30:0]             rad,
  output arith_rsp_t              rsp,
  output logic [WORD_W-1:0]       result
);

  localparam logic signed [ACC_W-1:0] LIM = 64'sd70368744177664; // 2^46

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        sqrt_r, sqrt_nxt;
  logic        neg_r, neg_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [62:0] q_r, q_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic [47:0] v_r, v_nxt;
  logic [47:0] res_r, res_nxt;
  logic [47:0] bit_r, bit_nxt;
  logic [31:0] result_r, result_nxt;

  always_comb begin
    logic [32:0]             rem_sh;
    logic [47:0]             trial;
    logic [46:0]             mag;
    logic signed [ACC_W-1:0] neg_num;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    sqrt_nxt   = sqrt_r;
    neg_nxt    = neg_r;
    cnt_nxt    = cnt_r;
    q_nxt      = q_r;
    rem_nxt    = rem_r;
    den_nxt    = den_r;
    v_nxt      = v_r;
    res_nxt    = res_r;
    bit_nxt    = bit_r;
    result_nxt = result_r;
    rem_sh     = {rem_r, q_r[62]};
    trial      = res_r + bit_r;
    neg_num    = -num;
    if (num > LIM || num < -LIM) begin
      mag = 47'h4000_0000_0000;
    end else if (num[ACC_W-1]) begin
      mag = neg_num[46:0];
    end else begin
      mag = num[46:0];
    end
    if (req.start) begin
      busy_nxt = 1'b1;
      sqrt_nxt = req.is_sqrt;
      neg_nxt  = num[ACC_W-1];
      q_nxt    = {mag, 16'd0};
      rem_nxt  = '0;
      den_nxt  = den;
      v_nxt    = {1'b0, rad, 16'd0};
      res_nxt  = '0;
      bit_nxt  = 48'h4000_0000_0000;
      cnt_nxt  = req.is_sqrt ? 6'd23 : 6'd62;
    end else if (busy_r) begin
      if (sqrt_r) begin
        if (v_r >= trial) begin
          v_nxt   = v_r - trial;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
      end else begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = 32'(rem_sh - {1'b0, den_r});
          q_nxt   = {q_r[61:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[31:0];
          q_nxt   = {q_r[61:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (sqrt_r) begin
          result_nxt = res_nxt[31:0];
        end else if (!neg_r) begin
          result_nxt = (q_nxt > 63'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_nxt[31:0];
        end else begin
          result_nxt = (q_nxt > 63'h8000_0000) ? 32'h8000_0000 : 32'(-q_nxt[31:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    sqrt_r   <= sqrt_nxt;
    neg_r    <= neg_nxt;
    cnt_r    <= cnt_nxt;
    q_r      <= q_nxt;
    rem_r    <= rem_nxt;
    den_r    <= den_nxt;
    v_r      <= v_nxt;
    res_r    <= res_nxt;
    bit_r    <= bit_nxt;
    result_r <= result_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign result   = result_r;

endmodule
